// File: rtl/ndfc_pkg.sv
// Package for the NMEA decimal field converter.
// Holds character codes, mode codes, widths and the scaling constants and helpers.
// No dependencies.
`timescale 1ns / 1ps

package ndfc_pkg;

	// Fraction digits kept per field (later ones are dropped)
	localparam int FRACTION_DIGITS = 4;
	localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);

	// Character codes
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// field_mode codes; the unused code falls back to integer
	localparam logic [1:0] MODE_LOCATION = 2'd0;
	localparam logic [1:0] MODE_TENTHS   = 2'd1;
	localparam logic [1:0] MODE_INTEGER  = 2'd2;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_FIELD_MODE = 1'b0;   // register index from paddr[2]

	// Integer part kept split as hundreds (hi) and last two digits (lo)
	localparam int HI_W     = 24;             // holds up to 9999999
	localparam int HI_EXT_W = 27;             // hi*10 + carry before saturation
	localparam int LO_W     = 7;
	localparam int TLO_W    = 10;             // lo*10 + digit
	localparam logic [HI_EXT_W-1:0] HI_SAT = HI_EXT_W'(9999999);
	localparam logic [LO_W-1:0]     LO_SAT = LO_W'(99);

	// Fraction in 1/10000 units and the first fraction digit
	localparam int FRAC_W  = 14;
	localparam int DIGIT_W = 4;

	// Output scaling
	localparam int KHI_W = 20;
	localparam int KLO_W = 14;
	localparam int PROD_W = HI_W + KHI_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int VAL_W  = 34;
	localparam logic [SUM_W-1:0] OUT_SAT = SUM_W'(64'd9999999999);

	localparam logic [KHI_W-1:0] K_HI_LOCATION = KHI_W'(600000);
	localparam logic [KLO_W-1:0] K_LO_LOCATION = KLO_W'(10000);
	localparam logic [KHI_W-1:0] K_HI_TENTHS   = KHI_W'(1000);
	localparam logic [KLO_W-1:0] K_LO_TENTHS   = KLO_W'(10);
	localparam logic [KHI_W-1:0] K_HI_INTEGER  = KHI_W'(100);
	localparam logic [KLO_W-1:0] K_LO_INTEGER  = KLO_W'(1);

	// Accumulated field state
	typedef struct packed {
		logic [HI_W-1:0]    hi;
		logic [LO_W-1:0]    lo;
		logic [FRAC_W-1:0]  frac4;
		logic [DIGIT_W-1:0] tenth;
	} ndfc_snap_t;

	// Weight of a fraction digit in 1/10000 units by its position
	function automatic logic [FRAC_W-1:0] frac_weight(input logic [CNT_W-1:0] pos);
		logic [FRAC_W-1:0] w;
		begin
			case (int'(pos))
				0:       w = FRAC_W'(1000);
				1:       w = FRAC_W'(100);
				2:       w = FRAC_W'(10);
				3:       w = FRAC_W'(1);
				default: w = '0;
			endcase
			return w;
		end
	endfunction

	// Hundreds digit of a value below 1000
	function automatic logic [DIGIT_W-1:0] hundreds(input logic [TLO_W-1:0] t);
		logic [DIGIT_W-1:0] q;
		begin
			q = '0;
			for (int j = 1; j <= 9; j++) begin
				if (t >= TLO_W'(100 * j)) q = DIGIT_W'(j);
			end
			return q;
		end
	endfunction

endpackage

// File: rtl/ndfc_accum.sv
// Digit accumulator of the NMEA decimal field converter.
// Builds integer and fraction state from accepted characters; clears on comma.
// Depends on ndfc_pkg.
`timescale 1ns / 1ps

module ndfc_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         char_code,
	output ndfc_pkg::ndfc_snap_t snap
);
	import ndfc_pkg::*;

	logic [HI_W-1:0]    hi_q;
	logic [LO_W-1:0]    lo_q;
	logic [FRAC_W-1:0]  frac4_q;
	logic [DIGIT_W-1:0] tenth_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               point_q;

	logic               is_digit;
	logic [DIGIT_W-1:0] digit;
	logic [TLO_W-1:0]   t_lo;
	logic [DIGIT_W-1:0] carry;
	logic [TLO_W-1:0]   lo_rem;
	logic [HI_EXT_W-1:0] hi_ext;
	logic [FRAC_W-1:0]  frac_add;

	// Character decode
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign digit    = DIGIT_W'(char_code - CHAR_ZERO);

	// Integer step: (hi*100 + lo)*10 + d, kept split at the hundreds
	assign t_lo   = TLO_W'(lo_q) * TLO_W'(10) + TLO_W'(digit);
	assign carry  = hundreds(t_lo);
	assign lo_rem = t_lo - TLO_W'(carry) * TLO_W'(100);
	assign hi_ext = HI_EXT_W'(hi_q) * HI_EXT_W'(10) + HI_EXT_W'(carry);

	// Fraction step in 1/10000 units
	assign frac_add = FRAC_W'(digit) * frac_weight(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q    <= '0;
			lo_q    <= '0;
			frac4_q <= '0;
			tenth_q <= '0;
			cnt_q   <= '0;
			point_q <= 1'b0;
		end else if (take) begin
			if (char_code == CHAR_COMMA) begin
				hi_q    <= '0;
				lo_q    <= '0;
				frac4_q <= '0;
				tenth_q <= '0;
				cnt_q   <= '0;
				point_q <= 1'b0;
			end else if (char_code == CHAR_POINT) begin
				point_q <= 1'b1;
			end else if (is_digit && !point_q) begin
				// saturate at 999999999
				if (hi_ext > HI_SAT) begin
					hi_q <= HI_W'(HI_SAT);
					lo_q <= LO_SAT;
				end else begin
					hi_q <= hi_ext[HI_W-1:0];
					lo_q <= lo_rem[LO_W-1:0];
				end
			end else if (is_digit && (cnt_q < CNT_W'(FRACTION_DIGITS))) begin
				if (cnt_q == '0) tenth_q <= digit;
				frac4_q <= frac4_q + frac_add;
				cnt_q   <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign snap.hi    = hi_q;
	assign snap.lo    = lo_q;
	assign snap.frac4 = frac4_q;
	assign snap.tenth = tenth_q;

endmodule

// File: rtl/nmea_decimal_field_converter.sv
// NMEA decimal field converter: one ASCII character per item, result on comma.
// A taken comma loads the field register; the result moves on into the output
// register when that register is free, and is then offered as the output item.
// Throughput: one character per cycle; stall only when the field register and
// the output register both hold results not yet taken.
// Reset clears the field state, the pipeline valids and field_mode (location).
// Depends on ndfc_pkg and ndfc_accum.
`timescale 1ns / 1ps

module nmea_decimal_field_converter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      char_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [33:0]                     field_value,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ndfc_pkg::PADDR_W-1:0]    paddr,
	input  logic [ndfc_pkg::PDATA_W-1:0]    pwdata,
	output logic [ndfc_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import ndfc_pkg::*;

	logic [1:0]   field_mode_q;
	ndfc_snap_t   snap;
	ndfc_snap_t   snap_s1;
	logic [1:0]   mode_s1;
	logic         vld_s1;
	logic         out_valid_q;
	logic [VAL_W-1:0] field_value_q;

	logic         in_fire;
	logic         is_comma;
	logic         out_free;
	logic [KHI_W-1:0] k_hi;
	logic [KLO_W-1:0] k_lo;
	logic [FRAC_W-1:0] low_add;
	logic [PROD_W-1:0] prod_hi;
	logic [SUM_W-1:0]  sum;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FIELD_MODE) ? PDATA_W'(field_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_mode_q <= MODE_LOCATION;
		end else if (psel && penable && pwrite && (paddr[2] == REG_FIELD_MODE)) begin
			field_mode_q <= pwdata[1:0];
		end
	end

	// Handshake
	assign is_comma = (char_code == CHAR_COMMA);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = vld_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;

	ndfc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_fire),
		.char_code (char_code),
		.snap      (snap)
	);

	// Field register: snapshot of the state when a comma is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (out_free || !vld_s1) begin
			vld_s1 <= in_fire && is_comma;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_comma) begin
			snap_s1 <= snap;
			mode_s1 <= field_mode_q;
		end
	end

	// Scaling: hi*k_hi + lo*k_lo + fraction term, saturated
	always_comb begin
		case (mode_s1)
			MODE_LOCATION: begin
				k_hi    = K_HI_LOCATION;
				k_lo    = K_LO_LOCATION;
				low_add = snap_s1.frac4;
			end
			MODE_TENTHS: begin
				k_hi    = K_HI_TENTHS;
				k_lo    = K_LO_TENTHS;
				low_add = FRAC_W'(snap_s1.tenth);
			end
			default: begin
				k_hi    = K_HI_INTEGER;
				k_lo    = K_LO_INTEGER;
				low_add = '0;
			end
		endcase
	end

	assign prod_hi = PROD_W'(snap_s1.hi) * PROD_W'(k_hi);
	assign sum     = SUM_W'(prod_hi) + SUM_W'(snap_s1.lo) * SUM_W'(k_lo) + SUM_W'(low_add);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s1) begin
			field_value_q <= (sum > OUT_SAT) ? VAL_W'(OUT_SAT) : sum[VAL_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign field_value = field_value_q;

endmodule

// File: tb/tb.sv
// Testbench for nmea_decimal_field_converter: directed and random character streams.
// Checks every converted field against an in-bench predictor under random idling.
// Depends on ndfc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;
	import ndfc_pkg::*;

	// Unused mode code, expected to act like the integer mode
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] ADDR_FIELD_MODE = {REG_FIELD_MODE, 2'b00};

	// Conversion constants
	localparam logic [29:0] INT_LIMIT   = 30'd999999999;
	localparam logic [63:0] VALUE_LIMIT = 64'd9999999999;
	localparam logic [63:0] DEG_SCALE   = 64'd600000;
	localparam logic [63:0] MIN_SCALE   = 64'd10000;
	localparam logic [63:0] TENTH_DIV   = 64'd1000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_CHARS   = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] char_code;
	logic out_valid;
	logic out_stall;
	logic [33:0] field_value;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// Predictor state
	logic [1:0]  cur_mode;
	logic [29:0] acc_int;
	logic [13:0] acc_frac;
	logic [2:0]  frac_count;
	logic        point_seen;

	logic [33:0] pending_values[$];
	int fail_count = 0;
	int useful_chars = 0;
	bit idle_free = 1'b0;

	nmea_decimal_field_converter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_value(field_value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// Predict the effect of one accepted character
	task automatic convert_char(input logic [7:0] c);
		logic [63:0] wide;
		logic [63:0] scaled;
		logic [63:0] val;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			useful_chars++;
			if (!point_seen) begin
				wide = 64'(acc_int) * 64'd10 + 64'(c - CHAR_ZERO);
				acc_int = (wide > 64'(INT_LIMIT)) ? INT_LIMIT : 30'(wide);
			end else if (int'(frac_count) < FRACTION_DIGITS) begin
				acc_frac = 14'(32'(acc_frac) * 10 + 32'(c - CHAR_ZERO));
				frac_count = frac_count + 3'd1;
			end
		end else if (c == CHAR_POINT) begin
			useful_chars++;
			point_seen = 1'b1;
		end else if (c == CHAR_COMMA) begin
			useful_chars++;
			// fraction scaled to 1/10000 units
			scaled = 64'(acc_frac);
			for (int k = int'(frac_count); k < FRACTION_DIGITS; k++)
				scaled = scaled * 64'd10;
			case (cur_mode)
				MODE_LOCATION: val = (64'(acc_int) / 64'd100) * DEG_SCALE +
					(64'(acc_int) % 64'd100) * MIN_SCALE + scaled;
				MODE_TENTHS: val = 64'(acc_int) * 64'd10 + scaled / TENTH_DIV;
				default: val = 64'(acc_int);
			endcase
			if (val > VALUE_LIMIT)
				val = VALUE_LIMIT;
			pending_values.push_back(34'(val));
			acc_int = '0;
			acc_frac = '0;
			frac_count = '0;
			point_seen = 1'b0;
		end
	endtask

	// Send one character item; valid stays high across back-to-back items
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = idle_free ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (in_stall);
		convert_char(c);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(8'(s[i]));
	endtask

	// Hold off input until every expected result is out, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_field_mode(output logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_FIELD_MODE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write field_mode with random upper bits, then read it back
	task automatic write_field_mode(input logic [1:0] m);
		logic [PDATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_FIELD_MODE;
		pwdata <= {30'($urandom), m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_mode = m;
		@(posedge clk);
		read_field_mode(rd);
		if (rd !== PDATA_W'(m)) begin
			$error("field_mode: expected %0d, got %0d", m, rd);
			fail_count++;
		end
	endtask

	// Reset value of the mode, empty field and a plain location
	task automatic test_reset_defaults();
		logic [PDATA_W-1:0] rd;
		read_field_mode(rd);
		if (rd !== PDATA_W'(MODE_LOCATION)) begin
			$error("field_mode: expected %0d, got %0d", MODE_LOCATION, rd);
			fail_count++;
		end
		send_string(",4807.038,");
		drain_results();
	endtask

	// Saturation, excess fraction digits, second point and ignored characters
	task automatic test_location_limits();
		send_string("9999999999.12345,");
		send_string("12.3.4");
		send_char(8'h00);
		send_char(8'hFF);
		send_string("x,");
		drain_results();
	endtask

	task automatic test_tenths_mode();
		write_field_mode(MODE_TENTHS);
		send_string("5.97,");
		drain_results();
	endtask

	task automatic test_integer_mode();
		write_field_mode(MODE_INTEGER);
		send_string("235959.99,");
		drain_results();
	endtask

	task automatic test_unused_mode();
		write_field_mode(MODE_UNUSED);
		send_string("7.1,");
		drain_results();
	endtask

	// One field: mostly well formed, sometimes noise or missing its comma
	task automatic send_random_field();
		int kind;
		int n_int;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			n_int = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
			repeat (n_int) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 3) != 0) begin
				send_char(CHAR_POINT);
				repeat ($urandom_range(0, 6)) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 19) == 0)
				send_char(8'($urandom_range(0, 255)));
			send_char(CHAR_COMMA);
		end else begin
			repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
			if (kind < 95)
				send_char(CHAR_COMMA);
		end
	endtask

	// Random phases through every mode, the extremes included
	task automatic test_random_fields();
		int target;
		for (int p = 0; p < 5; p++) begin
			write_field_mode((p < 4) ? 2'(p) : 2'($urandom_range(0, 3)));
			target = useful_chars + PHASE_CHARS;
			while (useful_chars < target) begin
				if ($urandom_range(0, 7) == 0)
					idle_free = ($urandom_range(0, 2) == 0);
				send_random_field();
				if ($urandom_range(0, 29) == 0)
					drain_results();
			end
			send_char(CHAR_COMMA);
			drain_results();
		end
		idle_free = 1'b0;
	endtask

	// Result checker with random output stall
	initial begin : result_checker
		int hold;
		logic [33:0] want;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = idle_free ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (pending_values.size() == 0) begin
				$error("field_value: expected nothing, got %0d", field_value);
				fail_count++;
			end else begin
				want = pending_values.pop_front();
				if (field_value !== want) begin
					$error("field_value: expected %0d, got %0d", want, field_value);
					fail_count++;
				end
			end
		end
	end

	// Run limit
	initial begin : run_limit
		#6ms;
		$display("tb failed");
		$finish;
	end

	initial begin : main_sequence
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_code <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cur_mode = MODE_LOCATION;
		acc_int = '0;
		acc_frac = '0;
		frac_count = '0;
		point_seen = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_location_limits();
		test_tenths_mode();
		test_integer_mode();
		test_unused_mode();
		test_random_fields();
		drain_results();

		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
